>>> rtl/ord_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ord_pkg - shared types and constants for the output-restricted deque
// Command and result codes, sizing, and the control/status bundles that
// join the controller to the datapath.
// ============================================================================
package ord_pkg;

	localparam int DEPTH = 8;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(DEPTH - 1);
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		CMD_INS_REAR  = 2'd0,
		CMD_INS_FRONT = 2'd1,
		CMD_DEL_FRONT = 2'd2,
		CMD_DUMP      = 2'd3
	} ord_op_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_OVERFLOW      = 3'd1,
		ST_FRONT_BLOCKED = 3'd2,
		ST_REAR_BLOCKED  = 3'd3,
		ST_UNDERFLOW     = 3'd4,
		ST_EMPTY         = 3'd5
	} ord_status_t;

	// controller -> datapath
	typedef struct packed {
		logic do_op;      // execute the accepted command, load first result
		logic dump_next;  // load the next dumped element
	} ord_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic dump_more;  // accepted command is a dump with more than one element
		logic ptr_last;   // dump pointer sits on the rear element
	} ord_sts_t;

endpackage

>>> rtl/output_restricted_deque.sv
`timescale 1ns / 1ps
// ============================================================================
// output_restricted_deque - deque in a linear array, removal at front only
// Commands insert at either end, delete from the front, or dump the
// contents front to rear. Each command yields one or more result beats.
// ============================================================================
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------
//   input   | in_valid / in_stall  | cmd[1:0], value[31:0] signed
//   output  | out_valid / out_stall| status[2:0], data[31:0], last
//
// Beats: insert and delete give one beat; a dump of N elements gives N
//   beats, the dump sequencer holding the input stalled after the first.
//   One beat per cycle is the limit while out_stall is low, set by the
//   single slot read port feeding the result register.
// Reset: arst_n clears the indices, sets the deque empty and drops
//   out_valid; slot contents are not cleared.
// Stalls: the result register frees when its beat is taken, so a new
//   command is accepted in the same cycle the previous beat leaves.
//
module output_restricted_deque
	import ord_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               cmd,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               status,
	output logic signed [DATA_W-1:0] data,
	output logic                     last
);

	ord_cmd_t ctl;
	ord_sts_t sts;

	// handshake and dump sequencing
	ord_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	// storage, indices and the result register
	ord_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.cmd    (cmd),
		.value  (value),
		.status (status),
		.data   (data),
		.last   (last)
	);

endmodule

>>> rtl/ord_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// ord_dp - deque datapath
// Slot storage, front/rear indices, empty flag, dump pointer and the
// result register.
// ============================================================================
module ord_dp
	import ord_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  ord_cmd_t                 ctl,
	output ord_sts_t                 sts,
	input  logic [1:0]               cmd,
	input  logic signed [DATA_W-1:0] value,
	output logic [2:0]               status,
	output logic signed [DATA_W-1:0] data,
	output logic                     last
);

	logic [DATA_W-1:0] slots_q [DEPTH];
	logic [IDX_W-1:0]  front_q;
	logic [IDX_W-1:0]  rear_q;
	logic              empty_q;
	logic [IDX_W-1:0]  ptr_q;

	ord_status_t       status_q;
	logic [DATA_W-1:0] data_q;
	logic              last_q;

	ord_op_t           op;
	logic              full;

	assign op      = ord_op_t'(cmd);
	assign full    = !empty_q && (rear_q == TOP_IDX) && (front_q == '0);

	assign sts.dump_more = (op == CMD_DUMP) && !empty_q && (front_q != rear_q);
	assign sts.ptr_last  = (ptr_q == rear_q);

	assign status = status_q;
	assign data   = data_q;
	assign last   = last_q;

	// slot writes
	always_ff @(posedge clk) begin
		if (ctl.do_op && (op == CMD_INS_REAR || op == CMD_INS_FRONT) && !full) begin
			if (empty_q) begin
				slots_q[0] <= value;
			end else if (op == CMD_INS_FRONT) begin
				if (front_q != '0) begin
					slots_q[front_q - 1'b1] <= value;
				end
			end else if (rear_q != TOP_IDX) begin
				slots_q[rear_q + 1'b1] <= value;
			end
		end
	end

	// indices and empty flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
			ptr_q   <= '0;
		end else if (ctl.do_op) begin
			case (op)
				CMD_INS_REAR, CMD_INS_FRONT: begin
					if (full) begin
						empty_q <= empty_q;
					end else if (empty_q) begin
						front_q <= '0;
						rear_q  <= '0;
						empty_q <= 1'b0;
					end else if (op == CMD_INS_FRONT) begin
						if (front_q != '0) front_q <= front_q - 1'b1;
					end else if (rear_q != TOP_IDX) begin
						rear_q <= rear_q + 1'b1;
					end
				end
				CMD_DEL_FRONT: begin
					if (!empty_q) begin
						if (front_q >= rear_q) begin
							empty_q <= 1'b1;
							front_q <= '0;
							rear_q  <= '0;
						end else begin
							front_q <= front_q + 1'b1;
						end
					end
				end
				CMD_DUMP: begin
					ptr_q <= front_q + 1'b1;
				end
				default: begin
					ptr_q <= ptr_q;
				end
			endcase
		end else if (ctl.dump_next) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.do_op) begin
			last_q <= 1'b1;
			data_q <= '0;
			case (op)
				CMD_INS_REAR, CMD_INS_FRONT: begin
					if (full) status_q <= ST_OVERFLOW;
					else if (empty_q) status_q <= ST_OK;
					else if (op == CMD_INS_FRONT && front_q == '0) status_q <= ST_FRONT_BLOCKED;
					else if (op == CMD_INS_REAR && rear_q == TOP_IDX) status_q <= ST_REAR_BLOCKED;
					else status_q <= ST_OK;
				end
				CMD_DEL_FRONT: begin
					if (empty_q) begin
						status_q <= ST_UNDERFLOW;
					end else begin
						status_q <= ST_OK;
						data_q   <= slots_q[front_q];
					end
				end
				CMD_DUMP: begin
					if (empty_q) begin
						status_q <= ST_EMPTY;
					end else begin
						status_q <= ST_OK;
						data_q   <= slots_q[front_q];
						last_q   <= (front_q == rear_q);
					end
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end else if (ctl.dump_next) begin
			status_q <= ST_OK;
			data_q   <= slots_q[ptr_q];
			last_q   <= (ptr_q == rear_q);
		end
	end

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (front_q == '0 && rear_q == '0))
		else $error("empty deque with nonzero indices");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> (front_q <= rear_q))
		else $error("front index passed rear index");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.do_op && ctl.dump_next))
		else $error("command and dump step in the same cycle");

endmodule

>>> rtl/ord_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// ord_ctrl - deque controller
// Input/output handshake and the dump sequencer.
// ============================================================================
module ord_ctrl
	import ord_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output ord_cmd_t ctl,
	input  ord_sts_t sts
);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_load;
	logic   load;

	assign can_load      = !out_valid_q || !out_stall;
	assign in_stall      = !((state_q == S_IDLE) && can_load);
	assign ctl.do_op     = in_valid && !in_stall;
	assign ctl.dump_next = (state_q == S_DUMP) && can_load;
	assign load          = ctl.do_op || ctl.dump_next;
	assign out_valid     = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (ctl.do_op && sts.dump_more) state_q <= S_DUMP;
				end
				S_DUMP: begin
					if (ctl.dump_next && sts.ptr_last) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_dump_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> in_stall)
		else $error("input open during dump");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !load)
		else $error("held result beat overwritten");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("loaded result not presented");

endmodule
